// ===== rtl/core/dcst_pkg.sv =====
`default_nettype none

package dcst_pkg;

  // configuration register file
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_W       = 31;
  localparam int unsigned ALPHA_W     = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_INV_DX         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_DY         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_DX_SQUARED = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_DY_SQUARED = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UPWIND_WEIGHT  = 3'd4;

  localparam logic [CFG_W-1:0]   INV_RESET   = 31'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd0;

  // load enables of the two register ranks inside a multiplier
  typedef struct packed {
    logic pp;
    logic sum;
  } mul_en_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcst_mul.sv =====
`default_nettype none

// two-stage signed multiplier: 33x33 partial products, then one summing rank
module dcst_mul #(
  parameter int unsigned A_W = 33,
  parameter int unsigned B_W = 33
) (
  input  wire logic                   clk,
  input  wire dcst_pkg::mul_en_t      en,
  input  wire logic signed [A_W-1:0]  a,
  input  wire logic signed [B_W-1:0]  b,
  output logic signed [A_W+B_W-1:0]   p
);

  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned NA      = (A_W - 2) / CHUNK_W + 1;
  localparam int unsigned NB      = (B_W - 2) / CHUNK_W + 1;
  localparam int unsigned AE_W    = NA * CHUNK_W + 1;
  localparam int unsigned BE_W    = NB * CHUNK_W + 1;
  localparam int unsigned PP_W    = 2 * (CHUNK_W + 1);
  localparam int unsigned P_W     = A_W + B_W;
  localparam int unsigned ACC_W   = (NA + NB) * CHUNK_W + 2;

  logic signed [AE_W-1:0]    a_ext;
  logic signed [BE_W-1:0]    b_ext;
  logic signed [CHUNK_W:0]   a_chunk [NA];
  logic signed [CHUNK_W:0]   b_chunk [NB];
  logic signed [PP_W-1:0]    pp [NA][NB];
  logic signed [ACC_W-1:0]   acc;

  assign a_ext = AE_W'(a);
  assign b_ext = BE_W'(b);

  // low chunks are unsigned, the top chunk carries the sign
  for (genvar k = 0; k < NA; k++) begin : g_a
    if (k == NA - 1) begin : g_top
      assign a_chunk[k] = a_ext[AE_W-1 : k*CHUNK_W];
    end else begin : g_low
      assign a_chunk[k] = {1'b0, a_ext[k*CHUNK_W +: CHUNK_W]};
    end
  end

  for (genvar l = 0; l < NB; l++) begin : g_b
    if (l == NB - 1) begin : g_top
      assign b_chunk[l] = b_ext[BE_W-1 : l*CHUNK_W];
    end else begin : g_low
      assign b_chunk[l] = {1'b0, b_ext[l*CHUNK_W +: CHUNK_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.pp) begin
      for (int k = 0; k < NA; k++) begin
        for (int l = 0; l < NB; l++) begin
          pp[k][l] <= a_chunk[k] * b_chunk[l];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NA; k++) begin
      for (int l = 0; l < NB; l++) begin
        acc = acc + (ACC_W'(pp[k][l]) <<< (CHUNK_W * (k + l)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      p <= P_W'(acc);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/donor_cell_stencil_terms.sv =====
`default_nettype none

// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    six u and six v samples
// result    out        result_valid / result_stall  four second derivatives,
//                                                 four donor-cell terms
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one request per clock cycle sustained while result_stall is low, eleven register
// stages from accept to result_valid; the depth is set by three chained two-rank
// multipliers (products of the sums, alpha blend, spacing reciprocal)
// rst is synchronous and clears every valid bit and reloads the configuration
// registers with their defaults; cfg_ready is always high
// each stage loads when it is empty or the stage after it moves, so bubbles
// close up and item_stall rises only with all stages full and the result held
module donor_cell_stencil_terms #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,

  input  wire logic                                   item_valid,
  output logic                                        item_stall,
  input  wire logic signed [DATA_WIDTH-1:0]           u_center,
  input  wire logic signed [DATA_WIDTH-1:0]           u_west,
  input  wire logic signed [DATA_WIDTH-1:0]           u_east,
  input  wire logic signed [DATA_WIDTH-1:0]           u_south,
  input  wire logic signed [DATA_WIDTH-1:0]           u_north,
  input  wire logic signed [DATA_WIDTH-1:0]           u_northwest,
  input  wire logic signed [DATA_WIDTH-1:0]           v_center,
  input  wire logic signed [DATA_WIDTH-1:0]           v_west,
  input  wire logic signed [DATA_WIDTH-1:0]           v_east,
  input  wire logic signed [DATA_WIDTH-1:0]           v_south,
  input  wire logic signed [DATA_WIDTH-1:0]           v_north,
  input  wire logic signed [DATA_WIDTH-1:0]           v_southeast,

  output logic                                        result_valid,
  input  wire logic                                   result_stall,
  output logic signed [DATA_WIDTH-1:0]                u_xx,
  output logic signed [DATA_WIDTH-1:0]                u_yy,
  output logic signed [DATA_WIDTH-1:0]                v_xx,
  output logic signed [DATA_WIDTH-1:0]                v_yy,
  output logic signed [DATA_WIDTH-1:0]                usq_x,
  output logic signed [DATA_WIDTH-1:0]                uv_y,
  output logic signed [DATA_WIDTH-1:0]                uv_x,
  output logic signed [DATA_WIDTH-1:0]                vsq_y,

  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [dcst_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [dcst_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned SW   = W + 1;              // neighbor sum or difference
  localparam int unsigned EW   = W + 3;              // second difference
  localparam int unsigned PW   = 2 * W + 2;          // product of two sums
  localparam int unsigned CW   = 2 * W + 3;          // central and upwind parts
  localparam int unsigned AB_W = dcst_pkg::ALPHA_W + 1;
  localparam int unsigned IB_W = dcst_pkg::CFG_W + 1;
  localparam int unsigned AUW  = CW + AB_W;
  localparam int unsigned XW   = ((CW + F > AUW) ? CW + F : AUW) + 1;
  localparam int unsigned XPW  = XW + IB_W;
  localparam int unsigned SDW  = EW + IB_W;
  localparam int unsigned SH   = 3 * F + 2;
  localparam int unsigned FW   = (XPW > SH + W) ? XPW : SH + W;

  localparam int unsigned NUM_TERMS = 4;

  // convective terms
  localparam int unsigned CONV_USQ_X = 0;
  localparam int unsigned CONV_UV_Y  = 1;
  localparam int unsigned CONV_UV_X  = 2;
  localparam int unsigned CONV_VSQ_Y = 3;

  // second derivatives
  localparam int unsigned SD_U_XX = 0;
  localparam int unsigned SD_U_YY = 1;
  localparam int unsigned SD_V_XX = 2;
  localparam int unsigned SD_V_YY = 3;

  // stage numbers
  localparam int unsigned ST_IN      = 1;
  localparam int unsigned ST_SUM     = 2;
  localparam int unsigned ST_MUL1_PP = 3;
  localparam int unsigned ST_MUL1    = 4;
  localparam int unsigned ST_DIFF    = 5;
  localparam int unsigned ST_MUL2_PP = 6;
  localparam int unsigned ST_MUL2    = 7;
  localparam int unsigned ST_BLEND   = 8;
  localparam int unsigned ST_MUL3_PP = 9;
  localparam int unsigned ST_MUL3    = 10;
  localparam int unsigned ST_OUT     = 11;
  localparam int unsigned NUM_STAGES = ST_OUT;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [SW-1:0] add_s(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    return SW'(a) + SW'(b);
  endfunction

  function automatic logic signed [SW-1:0] sub_s(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    return SW'(a) - SW'(b);
  endfunction

  // lo - 2 mid + hi
  function automatic logic signed [EW-1:0] second_diff(input logic signed [W-1:0] lo,
                                                       input logic signed [W-1:0] mid,
                                                       input logic signed [W-1:0] hi);
    return EW'(lo) + EW'(hi) - (EW'(mid) <<< 1);
  endfunction

  // |s1| d1 - |s2| d2 from the signed products s d and the signs of s
  function automatic logic signed [CW-1:0] upwind_diff(input logic signed [PW-1:0] r1,
                                                       input logic signed [PW-1:0] r2,
                                                       input logic n1,
                                                       input logic n2);
    logic [CW-1:0] x1;
    logic [CW-1:0] x2;
    x1 = CW'(r1);
    x2 = CW'(r2);
    if (n1) begin
      x1 = ~x1;
    end
    if (!n2) begin
      x2 = ~x2;
    end
    return x1 + x2 + CW'(n1) + CW'(!n2);
  endfunction

  // clamp to the signed W-bit range
  function automatic logic signed [W-1:0] saturate(input logic signed [FW-1:0] v);
    logic [FW-W:0] top;
    top = v[FW-1:W-1];
    if (&top || !(|top)) begin
      return v[W-1:0];
    end else if (v[FW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [dcst_pkg::CFG_W-1:0]   inv_dx;
  logic [dcst_pkg::CFG_W-1:0]   inv_dy;
  logic [dcst_pkg::CFG_W-1:0]   inv_dx_squared;
  logic [dcst_pkg::CFG_W-1:0]   inv_dy_squared;
  logic [dcst_pkg::ALPHA_W-1:0] upwind_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_dx         <= dcst_pkg::INV_RESET;
      inv_dy         <= dcst_pkg::INV_RESET;
      inv_dx_squared <= dcst_pkg::INV_RESET;
      inv_dy_squared <= dcst_pkg::INV_RESET;
      upwind_weight  <= dcst_pkg::ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dcst_pkg::REG_INV_DX:         inv_dx         <= cfg_data[dcst_pkg::CFG_W-1:0];
        dcst_pkg::REG_INV_DY:         inv_dy         <= cfg_data[dcst_pkg::CFG_W-1:0];
        dcst_pkg::REG_INV_DX_SQUARED: inv_dx_squared <= cfg_data[dcst_pkg::CFG_W-1:0];
        dcst_pkg::REG_INV_DY_SQUARED: inv_dy_squared <= cfg_data[dcst_pkg::CFG_W-1:0];
        dcst_pkg::REG_UPWIND_WEIGHT:  upwind_weight  <= cfg_data[dcst_pkg::ALPHA_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // reciprocals and alpha as non-negative signed multiplier operands
  logic signed [IB_W-1:0] inv_dx_s;
  logic signed [IB_W-1:0] inv_dy_s;
  logic signed [IB_W-1:0] inv_dx_sq_s;
  logic signed [IB_W-1:0] inv_dy_sq_s;
  logic signed [AB_W-1:0] alpha_s;

  assign inv_dx_s    = {1'b0, inv_dx};
  assign inv_dy_s    = {1'b0, inv_dy};
  assign inv_dx_sq_s = {1'b0, inv_dx_squared};
  assign inv_dy_sq_s = {1'b0, inv_dy_squared};
  assign alpha_s     = {1'b0, upwind_weight};

  // ---------------------------------------------------------------------------
  // stage control: valid bit per stage, load when empty or the next one moves
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] ld;

  always_comb begin
    ld[NUM_STAGES] = !v[NUM_STAGES] || !result_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign item_stall   = !ld[ST_IN];
  assign result_valid = v[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[ST_IN]) begin
        v[ST_IN] <= item_valid;
      end
      for (int k = ST_IN + 1; k <= NUM_STAGES; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: input samples
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] st1_uc, st1_uw, st1_ue, st1_us, st1_un, st1_unw;
  logic signed [W-1:0] st1_vc, st1_vw, st1_ve, st1_vs, st1_vn, st1_vse;

  always_ff @(posedge clk) begin
    if (ld[ST_IN]) begin
      st1_uc  <= u_center;
      st1_uw  <= u_west;
      st1_ue  <= u_east;
      st1_us  <= u_south;
      st1_un  <= u_north;
      st1_unw <= u_northwest;
      st1_vc  <= v_center;
      st1_vw  <= v_west;
      st1_ve  <= v_east;
      st1_vs  <= v_south;
      st1_vn  <= v_north;
      st1_vse <= v_southeast;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: neighbor sums, differences and second differences
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] st2_s1 [NUM_TERMS];
  logic signed [SW-1:0] st2_t1 [NUM_TERMS];
  logic signed [SW-1:0] st2_d1 [NUM_TERMS];
  logic signed [SW-1:0] st2_s2 [NUM_TERMS];
  logic signed [SW-1:0] st2_t2 [NUM_TERMS];
  logic signed [SW-1:0] st2_d2 [NUM_TERMS];
  logic signed [EW-1:0] st2_e  [NUM_TERMS];

  always_ff @(posedge clk) begin
    if (ld[ST_SUM]) begin
      // d(u^2)/dx
      st2_s1[CONV_USQ_X] <= add_s(st1_uc, st1_ue);
      st2_t1[CONV_USQ_X] <= add_s(st1_uc, st1_ue);
      st2_d1[CONV_USQ_X] <= sub_s(st1_uc, st1_ue);
      st2_s2[CONV_USQ_X] <= add_s(st1_uw, st1_uc);
      st2_t2[CONV_USQ_X] <= add_s(st1_uw, st1_uc);
      st2_d2[CONV_USQ_X] <= sub_s(st1_uw, st1_uc);
      // d(uv)/dy at the u point
      st2_s1[CONV_UV_Y]  <= add_s(st1_vc, st1_ve);
      st2_t1[CONV_UV_Y]  <= add_s(st1_uc, st1_un);
      st2_d1[CONV_UV_Y]  <= sub_s(st1_uc, st1_un);
      st2_s2[CONV_UV_Y]  <= add_s(st1_vs, st1_vse);
      st2_t2[CONV_UV_Y]  <= add_s(st1_us, st1_uc);
      st2_d2[CONV_UV_Y]  <= sub_s(st1_us, st1_uc);
      // d(uv)/dx at the v point
      st2_s1[CONV_UV_X]  <= add_s(st1_uc, st1_un);
      st2_t1[CONV_UV_X]  <= add_s(st1_vc, st1_ve);
      st2_d1[CONV_UV_X]  <= sub_s(st1_vc, st1_ve);
      st2_s2[CONV_UV_X]  <= add_s(st1_uw, st1_unw);
      st2_t2[CONV_UV_X]  <= add_s(st1_vw, st1_vc);
      st2_d2[CONV_UV_X]  <= sub_s(st1_vw, st1_vc);
      // d(v^2)/dy
      st2_s1[CONV_VSQ_Y] <= add_s(st1_vc, st1_vn);
      st2_t1[CONV_VSQ_Y] <= add_s(st1_vc, st1_vn);
      st2_d1[CONV_VSQ_Y] <= sub_s(st1_vc, st1_vn);
      st2_s2[CONV_VSQ_Y] <= add_s(st1_vs, st1_vc);
      st2_t2[CONV_VSQ_Y] <= add_s(st1_vs, st1_vc);
      st2_d2[CONV_VSQ_Y] <= sub_s(st1_vs, st1_vc);
      // second differences
      st2_e[SD_U_XX] <= second_diff(st1_uw, st1_uc, st1_ue);
      st2_e[SD_U_YY] <= second_diff(st1_us, st1_uc, st1_un);
      st2_e[SD_V_XX] <= second_diff(st1_vw, st1_vc, st1_ve);
      st2_e[SD_V_YY] <= second_diff(st1_vs, st1_vc, st1_vn);
    end
  end

  // ---------------------------------------------------------------------------
  // stages 3-4: s t and s d products, second difference times 1/h^2
  // ---------------------------------------------------------------------------
  dcst_pkg::mul_en_t mul1_en;
  dcst_pkg::mul_en_t mul2_en;
  dcst_pkg::mul_en_t mul3_en;

  assign mul1_en = '{pp: ld[ST_MUL1_PP], sum: ld[ST_MUL1]};
  assign mul2_en = '{pp: ld[ST_MUL2_PP], sum: ld[ST_MUL2]};
  assign mul3_en = '{pp: ld[ST_MUL3_PP], sum: ld[ST_MUL3]};

  logic signed [PW-1:0]   m1_p1 [NUM_TERMS];
  logic signed [PW-1:0]   m1_p2 [NUM_TERMS];
  logic signed [PW-1:0]   m1_r1 [NUM_TERMS];
  logic signed [PW-1:0]   m1_r2 [NUM_TERMS];
  logic signed [SDW-1:0]  m_sd  [NUM_TERMS];
  logic signed [IB_W-1:0] sd_inv [NUM_TERMS];
  logic signed [IB_W-1:0] conv_inv [NUM_TERMS];

  // sign of s1 and s2 rides along with the products
  logic [NUM_TERMS-1:0] st3_neg1, st3_neg2, st4_neg1, st4_neg2;

  for (genvar j = 0; j < NUM_TERMS; j++) begin : g_mul1
    if (j == SD_U_XX || j == SD_V_XX) begin : g_x
      assign sd_inv[j] = inv_dx_sq_s;
    end else begin : g_y
      assign sd_inv[j] = inv_dy_sq_s;
    end

    dcst_mul #(.A_W(SW), .B_W(SW)) u_mul_p1 (
      .clk(clk), .en(mul1_en), .a(st2_s1[j]), .b(st2_t1[j]), .p(m1_p1[j])
    );
    dcst_mul #(.A_W(SW), .B_W(SW)) u_mul_p2 (
      .clk(clk), .en(mul1_en), .a(st2_s2[j]), .b(st2_t2[j]), .p(m1_p2[j])
    );
    dcst_mul #(.A_W(SW), .B_W(SW)) u_mul_r1 (
      .clk(clk), .en(mul1_en), .a(st2_s1[j]), .b(st2_d1[j]), .p(m1_r1[j])
    );
    dcst_mul #(.A_W(SW), .B_W(SW)) u_mul_r2 (
      .clk(clk), .en(mul1_en), .a(st2_s2[j]), .b(st2_d2[j]), .p(m1_r2[j])
    );
    dcst_mul #(.A_W(EW), .B_W(IB_W)) u_mul_sd (
      .clk(clk), .en(mul1_en), .a(st2_e[j]), .b(sd_inv[j]), .p(m_sd[j])
    );
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_TERMS; j++) begin
      if (ld[ST_MUL1_PP]) begin
        st3_neg1[j] <= st2_s1[j][SW-1];
        st3_neg2[j] <= st2_s2[j][SW-1];
      end
      if (ld[ST_MUL1]) begin
        st4_neg1[j] <= st3_neg1[j];
        st4_neg2[j] <= st3_neg2[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: central and upwind differences, second derivative rounding
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] st5_c [NUM_TERMS];
  logic signed [CW-1:0] st5_u [NUM_TERMS];
  logic signed [W-1:0]  sd_pipe [ST_DIFF:ST_MUL3][NUM_TERMS];

  always_ff @(posedge clk) begin
    if (ld[ST_DIFF]) begin
      for (int j = 0; j < NUM_TERMS; j++) begin
        st5_c[j]            <= CW'(m1_p1[j]) - CW'(m1_p2[j]);
        st5_u[j]            <= upwind_diff(m1_r1[j], m1_r2[j], st4_neg1[j], st4_neg2[j]);
        sd_pipe[ST_DIFF][j] <= saturate(FW'(m_sd[j]) >>> F);
      end
    end
    // second derivatives wait for the convective terms
    for (int k = ST_MUL2_PP; k <= ST_MUL3; k++) begin
      if (ld[k]) begin
        sd_pipe[k] <= sd_pipe[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 6-7: alpha times the upwind part
  // ---------------------------------------------------------------------------
  logic signed [AUW-1:0] m2_p [NUM_TERMS];
  logic signed [CW-1:0]  st6_c [NUM_TERMS];
  logic signed [CW-1:0]  st7_c [NUM_TERMS];

  for (genvar j = 0; j < NUM_TERMS; j++) begin : g_mul2
    dcst_mul #(.A_W(CW), .B_W(AB_W)) u_mul_alpha (
      .clk(clk), .en(mul2_en), .a(st5_u[j]), .b(alpha_s), .p(m2_p[j])
    );
  end

  always_ff @(posedge clk) begin
    if (ld[ST_MUL2_PP]) begin
      st6_c <= st5_c;
    end
    if (ld[ST_MUL2]) begin
      st7_c <= st6_c;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: central part scaled by 2^F plus the blended upwind part
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] st8_x [NUM_TERMS];

  always_ff @(posedge clk) begin
    if (ld[ST_BLEND]) begin
      for (int j = 0; j < NUM_TERMS; j++) begin
        st8_x[j] <= (XW'(st7_c[j]) <<< F) + XW'(m2_p[j]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 9-10: times the spacing reciprocal
  // ---------------------------------------------------------------------------
  logic signed [XPW-1:0] m3_p [NUM_TERMS];

  for (genvar j = 0; j < NUM_TERMS; j++) begin : g_mul3
    if (j == CONV_USQ_X || j == CONV_UV_X) begin : g_x
      assign conv_inv[j] = inv_dx_s;
    end else begin : g_y
      assign conv_inv[j] = inv_dy_s;
    end

    dcst_mul #(.A_W(XW), .B_W(IB_W)) u_mul_inv (
      .clk(clk), .en(mul3_en), .a(st8_x[j]), .b(conv_inv[j]), .p(m3_p[j])
    );
  end

  // ---------------------------------------------------------------------------
  // stage 11: floor by 2^(3F+2), clamp, result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      u_xx  <= sd_pipe[ST_MUL3][SD_U_XX];
      u_yy  <= sd_pipe[ST_MUL3][SD_U_YY];
      v_xx  <= sd_pipe[ST_MUL3][SD_V_XX];
      v_yy  <= sd_pipe[ST_MUL3][SD_V_YY];
      usq_x <= saturate(FW'(m3_p[CONV_USQ_X]) >>> SH);
      uv_y  <= saturate(FW'(m3_p[CONV_UV_Y]) >>> SH);
      uv_x  <= saturate(FW'(m3_p[CONV_UV_X]) >>> SH);
      vsq_y <= saturate(FW'(m3_p[CONV_VSQ_Y]) >>> SH);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic item_take;
  logic result_take;

  assign item_take   = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  // back pressure reaches the input only through a completely full pipe
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst) item_stall |-> (&v)
  ) else $error("item stalled with an empty stage in the pipe");

  // occupancy grows by one for a request taken and none delivered
  a_count_up: assert property (
    @(posedge clk) disable iff (rst)
      (item_take && !result_take) |=> ($countones(v) == $past($countones(v)) + 1)
  ) else $error("accepted request not held in the pipe");

  // occupancy shrinks by one for a result delivered and none taken
  a_count_down: assert property (
    @(posedge clk) disable iff (rst)
      (!item_take && result_take) |=> ($countones(v) == $past($countones(v)) - 1)
  ) else $error("delivered result not removed from the pipe");

  // a request in and a result out in the same cycle, or neither, keep the count
  a_count_same: assert property (
    @(posedge clk) disable iff (rst)
      (item_take == result_take) |=> ($countones(v) == $past($countones(v)))
  ) else $error("pipe occupancy changed without a handshake");

endmodule

`default_nettype wire

// ===== bench/dcst_checker.sv =====
package dcst_bench_pkg;

  localparam int unsigned SLOTS = 12;
  localparam int unsigned TERMS = 8;

  // positions of the samples within one stencil request
  typedef enum int unsigned {
    U_C, U_W, U_E, U_S, U_N, U_NW,
    V_C, V_W, V_E, V_S, V_N, V_SE
  } slot_e;

  // positions of the terms within one result
  typedef enum int unsigned {
    T_UXX, T_UYY, T_VXX, T_VYY, T_USQX, T_UVY, T_UVX, T_VSQY
  } term_e;

  typedef logic [SLOTS-1:0][31:0] stencil_t;
  typedef logic [TERMS-1:0][31:0] terms_t;

endpackage

module dcst_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic                                 item_stall,
  input  dcst_bench_pkg::stencil_t             samples,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  dcst_bench_pkg::terms_t               terms,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [dcst_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dcst_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int unsigned                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;

  // wide enough for the largest exact intermediate, no rounding until the end
  typedef logic signed [191:0] wide_t;

  localparam wide_t TERM_MAX = (wide_t'(1) <<< 31) - 1;
  localparam wide_t TERM_MIN = -(wide_t'(1) <<< 31);

  logic [dcst_pkg::CFG_W-1:0]   recip_dx, recip_dy, recip_dx2, recip_dy2;
  logic [dcst_pkg::ALPHA_W-1:0] blend;
  dcst_bench_pkg::terms_t       terms_due [$];
  dcst_bench_pkg::terms_t       due;
  string                        term_label [dcst_bench_pkg::TERMS] = '{
                                  "u_xx", "u_yy", "v_xx", "v_yy",
                                  "usq_x", "uv_y", "uv_x", "vsq_y"};

  function automatic wide_t widen(logic [31:0] raw);
    wide_t w;
    w = $signed(raw);
    return w;
  endfunction

  function automatic logic [31:0] saturate(wide_t v);
    if (v > TERM_MAX) return TERM_MAX[31:0];
    if (v < TERM_MIN) return TERM_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic wide_t magnitude(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] curvature(wide_t lo, wide_t mid, wide_t hi, wide_t recip);
    wide_t t;
    t = (lo + hi - (mid <<< 1)) * recip;
    return saturate(t >>> FRAC);
  endfunction

  // central product difference plus upwind correction, scaled by the spacing
  function automatic logic [31:0] flux(wide_t s1, wide_t t1, wide_t d1,
                                       wide_t s2, wide_t t2, wide_t d2,
                                       wide_t recip, wide_t alpha);
    wide_t central, upwind, t;
    central = (s1 * t1 - s2 * t2) <<< FRAC;
    upwind  = (magnitude(s1) * d1 - magnitude(s2) * d2) * alpha;
    t       = (central + upwind) * recip;
    return saturate(t >>> (3 * FRAC + 2));
  endfunction

  function automatic dcst_bench_pkg::terms_t predict_terms(dcst_bench_pkg::stencil_t s);
    wide_t                  uc, uw, ue, us, un, unw, vc, vw, ve, vs, vn, vse;
    dcst_bench_pkg::terms_t r;
    uc  = widen(s[dcst_bench_pkg::U_C]);
    uw  = widen(s[dcst_bench_pkg::U_W]);
    ue  = widen(s[dcst_bench_pkg::U_E]);
    us  = widen(s[dcst_bench_pkg::U_S]);
    un  = widen(s[dcst_bench_pkg::U_N]);
    unw = widen(s[dcst_bench_pkg::U_NW]);
    vc  = widen(s[dcst_bench_pkg::V_C]);
    vw  = widen(s[dcst_bench_pkg::V_W]);
    ve  = widen(s[dcst_bench_pkg::V_E]);
    vs  = widen(s[dcst_bench_pkg::V_S]);
    vn  = widen(s[dcst_bench_pkg::V_N]);
    vse = widen(s[dcst_bench_pkg::V_SE]);
    r[dcst_bench_pkg::T_UXX]  = curvature(uw, uc, ue, recip_dx2);
    r[dcst_bench_pkg::T_UYY]  = curvature(us, uc, un, recip_dy2);
    r[dcst_bench_pkg::T_VXX]  = curvature(vw, vc, ve, recip_dx2);
    r[dcst_bench_pkg::T_VYY]  = curvature(vs, vc, vn, recip_dy2);
    r[dcst_bench_pkg::T_USQX] = flux(uc + ue, uc + ue, uc - ue, uw + uc, uw + uc, uw - uc,
                                     recip_dx, blend);
    r[dcst_bench_pkg::T_UVY]  = flux(vc + ve, uc + un, uc - un, vs + vse, us + uc, us - uc,
                                     recip_dy, blend);
    r[dcst_bench_pkg::T_UVX]  = flux(uc + un, vc + ve, vc - ve, uw + unw, vw + vc, vw - vc,
                                     recip_dx, blend);
    r[dcst_bench_pkg::T_VSQY] = flux(vc + vn, vc + vn, vc - vn, vs + vc, vs + vc, vs - vc,
                                     recip_dy, blend);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      terms_due.delete();
      mismatches   = 0;
      recip_dx    <= dcst_pkg::INV_RESET;
      recip_dy    <= dcst_pkg::INV_RESET;
      recip_dx2   <= dcst_pkg::INV_RESET;
      recip_dy2   <= dcst_pkg::INV_RESET;
      blend       <= dcst_pkg::ALPHA_RESET;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dcst_pkg::REG_INV_DX:         recip_dx  <= cfg_data[dcst_pkg::CFG_W-1:0];
          dcst_pkg::REG_INV_DY:         recip_dy  <= cfg_data[dcst_pkg::CFG_W-1:0];
          dcst_pkg::REG_INV_DX_SQUARED: recip_dx2 <= cfg_data[dcst_pkg::CFG_W-1:0];
          dcst_pkg::REG_INV_DY_SQUARED: recip_dy2 <= cfg_data[dcst_pkg::CFG_W-1:0];
          dcst_pkg::REG_UPWIND_WEIGHT:  blend     <= cfg_data[dcst_pkg::ALPHA_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting so a stray result never meets a fresh request
      if (result_valid && !result_stall) begin
        if (terms_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no request outstanding at %0t", $realtime);
        end else begin
          due = terms_due.pop_front();
          for (int k = 0; k < dcst_bench_pkg::TERMS; k++) begin
            if (terms[k] !== due[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("%s mismatch at %0t: expected %0d, got %0d", term_label[k],
                         $realtime, $signed(due[k]), $signed(terms[k]));
            end
          end
        end
      end
      if (item_valid && !item_stall)
        terms_due.push_back(predict_terms(samples));
      outstanding <= $unsigned(terms_due.size());
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [dcst_pkg::CFG_INDEX_W-1:0] cfg_index_t;

  // far above the slowest legal run: ~1550 requests, 31% gaps and 31% stalls
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 192;
  // eleven pipeline stages plus margin for a late extra result
  localparam int          DRAIN_CYCLES  = 40;

  // indexes past the last register, writes there must be dropped
  localparam cfg_index_t REG_SPARE_FIRST = dcst_pkg::REG_UPWIND_WEIGHT + 3'd1;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // gently varying flow: u around 1.0, v around -1.0
  localparam dcst_bench_pkg::stencil_t SMOOTH = {
    32'hffff_2000, 32'hfffe_8000, 32'hffff_8000, 32'hfffe_c000, 32'hffff_4000, 32'hffff_0000,
    32'h0000_6000, 32'h0001_4000, 32'h0000_c000, 32'h0001_8000, 32'h0000_8000, 32'h0001_0000
  };

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    item_valid = 1'b0;
  dcst_bench_pkg::stencil_t                samples = '0;
  wire                                     item_stall;
  wire                                     result_valid;
  logic                                    result_stall = 1'b0;
  wire [dcst_bench_pkg::TERMS-1:0][31:0]   terms;
  logic                                    cfg_valid = 1'b0;
  wire                                     cfg_ready;
  cfg_index_t                              cfg_index = dcst_pkg::REG_INV_DX;
  logic [dcst_pkg::CFG_DATA_W-1:0]         cfg_data = '0;

  // calm phase: no gaps on the request side, no stalls on the result side
  logic                   calm = 1'b0;
  int                     mismatches;
  int unsigned            outstanding;
  int unsigned            cycle_count = 0;

  always #5 clk = ~clk;

  donor_cell_stencil_terms uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .u_center     (samples[dcst_bench_pkg::U_C]),
    .u_west       (samples[dcst_bench_pkg::U_W]),
    .u_east       (samples[dcst_bench_pkg::U_E]),
    .u_south      (samples[dcst_bench_pkg::U_S]),
    .u_north      (samples[dcst_bench_pkg::U_N]),
    .u_northwest  (samples[dcst_bench_pkg::U_NW]),
    .v_center     (samples[dcst_bench_pkg::V_C]),
    .v_west       (samples[dcst_bench_pkg::V_W]),
    .v_east       (samples[dcst_bench_pkg::V_E]),
    .v_south      (samples[dcst_bench_pkg::V_S]),
    .v_north      (samples[dcst_bench_pkg::V_N]),
    .v_southeast  (samples[dcst_bench_pkg::V_SE]),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .u_xx         (terms[dcst_bench_pkg::T_UXX]),
    .u_yy         (terms[dcst_bench_pkg::T_UYY]),
    .v_xx         (terms[dcst_bench_pkg::T_VXX]),
    .v_yy         (terms[dcst_bench_pkg::T_VYY]),
    .usq_x        (terms[dcst_bench_pkg::T_USQX]),
    .uv_y         (terms[dcst_bench_pkg::T_UVY]),
    .uv_x         (terms[dcst_bench_pkg::T_UVX]),
    .vsq_y        (terms[dcst_bench_pkg::T_VSQY]),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dcst_checker terms_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .samples      (samples),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .terms        (terms),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // result side backpressure, redrawn every cycle
  always @(posedge clk)
    result_stall <= !calm && ($urandom_range(0, 99) < 31);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic dcst_bench_pkg::stencil_t uniform(logic [31:0] v);
    return {dcst_bench_pkg::SLOTS{v}};
  endfunction

  function automatic dcst_bench_pkg::stencil_t negated(dcst_bench_pkg::stencil_t s);
    for (int k = 0; k < dcst_bench_pkg::SLOTS; k++) s[k] = -s[k];
    return s;
  endfunction

  // spacing reciprocal: zero, saturated, raw 32-bit noise or a plausible grid
  function automatic logic [31:0] draw_recip();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return '0;
    if (pick < 22) return Q_MAX | ($urandom & Q_MIN);
    if (pick < 37) return $urandom;
    return $urandom_range(32'h0000_1000, 32'h0040_0000);
  endfunction

  // blend factor: pure central, pure upwind, beyond one, raw noise, in between
  function automatic logic [31:0] draw_alpha();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 35) return 32'h0001_0000;
    if (pick < 45) return $urandom_range(32'h0001_0001, 32'h0001_ffff);
    if (pick < 55) return $urandom;
    return $urandom_range(0, 32'h0001_0000);
  endfunction

  // mostly a smooth field near a shared base so terms stay in range,
  // with unrelated values, full-width noise and rail values mixed in
  function automatic logic [31:0] draw_sample(logic [31:0] base);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return base + $urandom_range(0, 32'h8000) - 32'h4000;
    if (pick < 70) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (pick < 90) return $urandom;
    pick = $urandom_range(0, 4);
    if (pick == 0) return Q_MIN;
    if (pick == 1) return Q_MAX;
    if (pick == 2) return '0;
    if (pick == 3) return '1;
    return 32'd1;
  endfunction

  function automatic dcst_bench_pkg::stencil_t draw_stencil();
    dcst_bench_pkg::stencil_t s;
    logic [31:0]              base;
    base = ($urandom_range(0, 99) < 75) ?
           $urandom_range(0, 32'h0040_0000) - 32'h0020_0000 : $urandom;
    for (int k = 0; k < dcst_bench_pkg::SLOTS; k++) s[k] = draw_sample(base);
    return s;
  endfunction

  // offer one request, possibly after random gaps; valid stays high on return
  task automatic present(input dcst_bench_pkg::stencil_t s);
    while (!calm && $urandom_range(0, 99) < 31) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    samples    <= s;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // stop offering and wait for every predicted result to come back
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // reprogram the grid only with the pipeline empty
  task automatic program_grid(input logic [31:0] dx, input logic [31:0] dy,
                              input logic [31:0] dx2, input logic [31:0] dy2,
                              input logic [31:0] alpha, input bit stray);
    settle();
    write_reg(dcst_pkg::REG_INV_DX, dx);
    write_reg(dcst_pkg::REG_INV_DY, dy);
    write_reg(dcst_pkg::REG_INV_DX_SQUARED, dx2);
    write_reg(dcst_pkg::REG_INV_DY_SQUARED, dy2);
    write_reg(dcst_pkg::REG_UPWIND_WEIGHT, alpha);
    // a write to an unmapped index must leave everything untouched
    if (stray) write_reg(REG_SPARE_FIRST + cfg_index_t'($urandom_range(0, 2)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    dcst_bench_pkg::stencil_t spike, shear;
    // center at one rail, all neighbours at the other: worst second difference
    spike = uniform(Q_MAX);
    spike[dcst_bench_pkg::U_C] = Q_MIN;
    spike[dcst_bench_pkg::V_C] = Q_MIN;
    // u pinned high, v pinned low: worst mixed products
    shear = {{6{Q_MIN}}, {6{Q_MAX}}};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // values after reset: unit spacing, pure central differences
    present(uniform('0));
    present(uniform(Q_MAX));
    present(uniform(Q_MIN));
    present(spike);
    present(~spike);
    present(shear);
    present(~shear);
    present(SMOOTH);
    present(negated(SMOOTH));

    // 0.05 spacing, half upwind, plus an ignored write to a spare index
    program_grid(32'h0014_0000, 32'h0014_0000, 32'h0190_0000, 32'h0190_0000,
                 32'h0000_8000, 1'b1);
    present(SMOOTH);
    present(negated(SMOOTH));
    present(shear);

    // all ones: reciprocals clip to their top value, blend lands above one
    program_grid('1, '1, '1, '1, '1, 1'b0);
    present(SMOOTH);
    present(spike);
    present(uniform(Q_MIN));
    present(shear);

    // zero reciprocals zero every term regardless of the flow
    program_grid('0, '0, '0, '0, 32'h0001_0000, 1'b0);
    present(SMOOTH);
    present(uniform(Q_MAX));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_grid(draw_recip(), draw_recip(), draw_recip(), draw_recip(), draw_alpha(),
                   $urandom_range(0, 3) == 0);
      // one phase runs back to back with no backpressure at all
      calm <= (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) present(draw_stencil());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dcst_pkg.sv
rtl/core/dcst_mul.sv
rtl/core/donor_cell_stencil_terms.sv
bench/dcst_checker.sv
bench/tb.sv
